### sv/ring_fifo_with_overwrite_and_unpush_top_defines.svh
// ----------------------------------------------------------------------------
// Ring FIFO assertion macros
// Shared forms for the concurrent checks of the ring FIFO.
// ----------------------------------------------------------------------------
`ifndef RING_FIFO_WITH_OVERWRITE_AND_UNPUSH_TOP_DEFINES_SVH
`define RING_FIFO_WITH_OVERWRITE_AND_UNPUSH_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RFO_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring FIFO check failed");

// Next-cycle implication, disabled during reset.
`define RFO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring FIFO check failed");

`endif

### sv/rfo_pkg.sv
// ----------------------------------------------------------------------------
// Ring FIFO package
// Sizes, command codes, shared types and the ring address helper.
// ----------------------------------------------------------------------------
package rfo_pkg;

   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int KIND_W    = 3;

   localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UNPUSH  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DROP    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RANGE   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd6;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RDCAP
   } ctrl_state_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_W-1:0]    waddr;
      logic [WORD_BITS-1:0] wdata;
      logic                 re;
      logic [ADDR_W-1:0]    raddr;
   } mem_req_type;

   // Ring position of base plus off; the sum is always below twice the capacity.
   function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] base,
                                                  logic [CNT_W-1:0]  off,
                                                  logic [CNT_W-1:0]  cap);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(cap)) begin
         sum = sum - (CNT_W+1)'(cap);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

### sv/rfo_store.sv
// ----------------------------------------------------------------------------
// Ring FIFO word store
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module rfo_store (
   input  logic                          clock,
   input  rfo_pkg::mem_req_type          mem_req,
   output logic [rfo_pkg::WORD_BITS-1:0] rd_data
);
   import rfo_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= mem[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/rfo_ctrl.sv
// ----------------------------------------------------------------------------
// Ring FIFO controller
// Command register, ring pointers, sequencer and result register.
// ----------------------------------------------------------------------------
module rfo_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rfo_pkg::KIND_W-1:0]    req_kind,
   input  logic [rfo_pkg::WORD_BITS-1:0] req_data_in,
   input  logic                          req_overwrite,
   input  logic [rfo_pkg::ADDR_W-1:0]    req_start_index,
   input  logic [rfo_pkg::CNT_W-1:0]     req_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rfo_pkg::WORD_BITS-1:0] rsp_data_out,
   output logic                          rsp_ok,
   output logic                          rsp_last,
   output logic [rfo_pkg::CNT_W-1:0]     rsp_fill_level,
   input  logic                          csr_we,
   input  logic [rfo_pkg::CNT_W-1:0]     csr_wdata,
   output rfo_pkg::mem_req_type          mem_req,
   input  logic [rfo_pkg::WORD_BITS-1:0] rd_data
);
   import rfo_pkg::*;

   ctrl_state_type state_ff, state_in;

   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [WORD_BITS-1:0] data_ff, data_in;
   logic                 ovw_ff, ovw_in;
   logic [ADDR_W-1:0]    start_ff, start_in;
   logic [CNT_W-1:0]     amount_ff, amount_in;

   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     cap_ff, cap_in;
   logic [CNT_W-1:0]     off_ff, off_in;
   logic [CNT_W-1:0]     left_ff, left_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]     rsp_fill_ff, rsp_fill_in;

   logic                 out_free;
   logic                 accept;
   logic                 is_empty;
   logic                 is_full;
   logic                 range_bad;
   logic                 read_cmd;
   logic                 last_word;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign is_empty  = (fill_ff == '0);
   assign is_full   = (fill_ff >= cap_ff);
   assign range_bad = ((CNT_W+1)'(start_ff) + (CNT_W+1)'(amount_ff)) > (CNT_W+1)'(fill_ff);
   assign last_word = (left_ff == CNT_W'(1));

   always_comb begin
      case (kind_ff)
         KIND_POP, KIND_UNPUSH, KIND_PEEK: read_cmd = !is_empty;
         KIND_RANGE:                       read_cmd = !range_bad && (amount_ff != '0);
         default:                          read_cmd = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (read_cmd) begin
               state_in = S_RDCAP;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_RDCAP: begin
            if (out_free && last_word) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      kind_in      = kind_ff;
      data_in      = data_ff;
      ovw_in       = ovw_ff;
      start_in     = start_ff;
      amount_in    = amount_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      cap_in       = cap_ff;
      off_in       = off_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fill_in  = rsp_fill_ff;
      mem_req      = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               kind_in   = req_kind;
               data_in   = req_data_in;
               ovw_in    = req_overwrite;
               start_in  = req_start_index;
               amount_in = req_amount;
            end
         end
         S_EXEC: begin
            if (read_cmd) begin
               mem_req.re = 1'b1;
               left_in    = CNT_W'(1);
               case (kind_ff)
                  KIND_POP: begin
                     mem_req.raddr = head_ff;
                     head_in       = wrap_add(head_ff, CNT_W'(1), cap_ff);
                     fill_in       = fill_ff - CNT_W'(1);
                  end
                  KIND_UNPUSH, KIND_PEEK: begin
                     mem_req.raddr = wrap_add(head_ff, fill_ff - CNT_W'(1), cap_ff);
                     if (kind_ff == KIND_UNPUSH) begin
                        fill_in = fill_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     mem_req.raddr = wrap_add(head_ff, CNT_W'(start_ff), cap_ff);
                     off_in        = CNT_W'(start_ff) + CNT_W'(1);
                     left_in       = amount_ff;
                  end
               endcase
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_ok_in    = 1'b0;
               rsp_last_in  = 1'b1;
               case (kind_ff)
                  KIND_PUSH: begin
                     if (!is_full) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = wrap_add(head_ff, fill_ff, cap_ff);
                        mem_req.wdata = data_ff;
                        fill_in       = fill_ff + CNT_W'(1);
                        rsp_ok_in     = 1'b1;
                     end else if (ovw_ff) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = head_ff;
                        mem_req.wdata = data_ff;
                        head_in       = wrap_add(head_ff, CNT_W'(1), cap_ff);
                        rsp_ok_in     = 1'b1;
                     end
                  end
                  KIND_DROP: begin
                     if (amount_ff <= fill_ff) begin
                        fill_in   = fill_ff - amount_ff;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  KIND_RANGE: begin
                     rsp_ok_in = !range_bad;
                  end
                  KIND_CLEAR: begin
                     fill_in   = '0;
                     head_in   = '0;
                     rsp_ok_in = 1'b1;
                  end
                  default: begin
                     rsp_ok_in = 1'b0;
                  end
               endcase
               rsp_fill_in = fill_in;
            end
         end
         S_RDCAP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data;
               rsp_ok_in    = 1'b1;
               rsp_last_in  = last_word;
               rsp_fill_in  = fill_ff;
               if (!last_word) begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = wrap_add(head_ff, off_ff, cap_ff);
                  off_in        = off_ff + CNT_W'(1);
                  left_in       = left_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase

      if (csr_we) begin
         if (csr_wdata == '0) begin
            cap_in = CNT_W'(1);
         end else if (csr_wdata > CNT_W'(DEPTH)) begin
            cap_in = CNT_W'(DEPTH);
         end else begin
            cap_in = csr_wdata;
         end
         head_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      data_ff     <= data_in;
      ovw_ff      <= ovw_in;
      start_ff    <= start_in;
      amount_ff   <= amount_in;
      off_ff      <= off_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_fill_level = rsp_fill_ff;

endmodule

### sv/ring_fifo_with_overwrite_and_unpush_top.sv
// ----------------------------------------------------------------------------
// Ring FIFO with overwrite and unpush
// Circular word FIFO with push, pop, newest-end removal and range reads.
// ----------------------------------------------------------------------------
// A command word is taken, executed in the execute state and answered through
// a result register, so the next command can arrive while a result waits.
// Push, drop, clear and failing commands pass through the execute state only;
// pop, unpush and peek also pass through the read-capture state, because the
// word store registers its read data; a read range yields one word per cycle
// while the result side keeps up. No clearing pass follows reset.
module ring_fifo_with_overwrite_and_unpush_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rfo_pkg::KIND_W-1:0]    req_kind,
   input  logic [rfo_pkg::WORD_BITS-1:0] req_data_in,
   input  logic                          req_overwrite,
   input  logic [rfo_pkg::ADDR_W-1:0]    req_start_index,
   input  logic [rfo_pkg::CNT_W-1:0]     req_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rfo_pkg::WORD_BITS-1:0] rsp_data_out,
   output logic                          rsp_ok,
   output logic                          rsp_last,
   output logic [rfo_pkg::CNT_W-1:0]     rsp_fill_level,
   input  logic                          csr_we,
   input  logic [rfo_pkg::CNT_W-1:0]     csr_wdata
);
   import rfo_pkg::*;

   mem_req_type          mem_req;
   logic [WORD_BITS-1:0] rd_data;

   rfo_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_in     (req_data_in),
      .req_overwrite   (req_overwrite),
      .req_start_index (req_start_index),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_out    (rsp_data_out),
      .rsp_ok          (rsp_ok),
      .rsp_last        (rsp_last),
      .rsp_fill_level  (rsp_fill_level),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mem_req         (mem_req),
      .rd_data         (rd_data)
   );

   rfo_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

### sv/rfo_checker.sv
// ----------------------------------------------------------------------------
// Ring FIFO checker
// Port-level checks on the ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "ring_fifo_with_overwrite_and_unpush_top_defines.svh"

module rfo_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rfo_pkg::WORD_BITS-1:0] rsp_data_out,
   input logic                          rsp_ok,
   input logic                          rsp_last,
   input logic [rfo_pkg::CNT_W-1:0]     rsp_fill_level
);
   import rfo_pkg::*;

   logic               rsp_stall;
   logic               rsp_fail;
   logic [WORD_BITS:0] rsp_shown;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_fail  = rsp_valid && !rsp_ok;
   assign rsp_shown = {rsp_last, rsp_data_out};

   `RFO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_shown))
   `RFO_ASSERT_IMPL(a_fail_shape, clock, reset, rsp_fail, rsp_last && (rsp_data_out == '0))
   `RFO_ASSERT_IMPL(a_fill_range, clock, reset, rsp_valid, rsp_fill_level <= CNT_W'(DEPTH))
   `RFO_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind ring_fifo_with_overwrite_and_unpush_top rfo_checker u_rfo_checker (.*);
